// ===== hdl/phsl_pkg.sv =====
package phsl_pkg;

	localparam logic [1:0] ACT_KEY = 2'd0;
	localparam logic [1:0] ACT_WR_MAP = 2'd1;
	localparam logic [1:0] ACT_WR_MUL = 2'd2;

	localparam logic CFG_SLOT_COUNT = 1'b0;
	localparam logic CFG_BUCKET_COUNT = 1'b1;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_NOT_INIT = 1'b1;

	localparam logic [63:0] DJB_SEED = 64'd5381;
	localparam logic [63:0] FNV_SEED = 64'd14695981039346656037;

	localparam logic DIV_SEL_BUCKET = 1'b0;
	localparam logic DIV_SEL_SLOT = 1'b1;

	typedef struct packed {
		logic hash_upd;
		logic hash_seed;
		logic map_wr;
		logic mul_wr;
		logic div_start;
		logic div_sel;
		logic bucket_ld;
		logic map_rd;
		logic mul_rd;
		logic mul_lo;
		logic mul_hi;
		logic sum_ld;
		logic out_ld;
		logic not_init;
	} phsl_cmd_t;

	typedef struct packed {
		logic div_done;
		logic slot_zero;
		logic out_free;
	} phsl_status_t;

endpackage

// ===== hdl/phsl_div.sv =====
module phsl_div import phsl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] remainder
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] dvd_q;
	logic [31:0] dvs_q;
	logic [31:0] rem_q;
	logic [32:0] trial;
	logic [31:0] rem_next;

	// Restoring division, one quotient bit per cycle; only the remainder is kept.
	always_comb begin
		trial = {rem_q, dvd_q[63]};
		if (trial >= {1'b0, dvs_q}) begin
			rem_next = 32'(trial - {1'b0, dvs_q});
		end else begin
			rem_next = trial[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[62:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign remainder = rem_q;

endmodule

// ===== hdl/phsl_dp.sv =====
module phsl_dp import phsl_pkg::*; #(
	parameter int BUCKET_DEPTH = 4096,
	parameter int MULTIPLIER_DEPTH = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic [7:0]   key_byte,
	input  logic [11:0]  entry_index,
	input  logic [7:0]   multiplier_id,
	input  logic [31:0]  alpha,
	input  logic [31:0]  beta,
	input  logic         out_stall,
	input  phsl_cmd_t    cmd,
	output phsl_status_t st,
	output logic         out_valid,
	output logic [31:0]  slot_index,
	output logic [11:0]  bucket_index,
	output logic         status
);

	localparam int BW = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
	localparam int MW = (MULTIPLIER_DEPTH > 1) ? $clog2(MULTIPLIER_DEPTH) : 1;
	localparam logic [31:0] BDEP = 32'(BUCKET_DEPTH);
	localparam logic [31:0] MDEP = 32'(MULTIPLIER_DEPTH);
	localparam logic [8:0] MDIV = 9'(MULTIPLIER_DEPTH);

	logic [31:0] slot_count_q;
	logic [12:0] bucket_count_q;
	logic [63:0] djb_q;
	logic [63:0] fnv_q;
	logic [BW-1:0] bucket_q;
	logic [7:0]  map_q;
	logic [63:0] mul_q;
	logic [63:0] lo_q;
	logic [63:0] hi_q;
	logic [63:0] sum_q;
	logic        out_valid_q;
	logic [31:0] slot_q;
	logic [11:0] bucket_out_q;
	logic        status_q;

	logic [7:0]  bucket_map [BUCKET_DEPTH];
	logic [63:0] multiplier_table [MULTIPLIER_DEPTH];

	logic [31:0] bc_eff;
	logic [63:0] div_dvd;
	logic [31:0] div_dvs;
	logic        div_done;
	logic [31:0] div_rem;
	logic [63:0] fnv_x;
	logic [MW-1:0] mid;

	// Map entry reduced modulo the multiplier depth, eight restoring steps.
	function automatic logic [MW-1:0] mid_mod(input logic [7:0] v);
		logic [8:0] r;
		r = '0;
		for (int i = 7; i >= 0; i--) begin
			r = {r[7:0], v[i]};
			if (r >= MDIV) begin
				r = r - MDIV;
			end
		end
		return MW'(r);
	endfunction

	always_comb begin
		bc_eff = {19'd0, bucket_count_q};
		if (bc_eff == 32'd0) begin
			bc_eff = 32'd1;
		end else if (bc_eff > BDEP) begin
			bc_eff = BDEP;
		end
	end

	assign div_dvd = (cmd.div_sel == DIV_SEL_SLOT) ? sum_q : djb_q;
	assign div_dvs = (cmd.div_sel == DIV_SEL_SLOT) ? slot_count_q : bc_eff;

	phsl_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.done      (div_done),
		.remainder (div_rem)
	);

	// FNV prime is 2^40 + 2^8 + 179, so the multiply is a sum of shifts.
	assign fnv_x = fnv_q ^ {56'd0, key_byte};
	assign mid = mid_mod(map_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= '0;
			bucket_count_q <= 13'd1;
			djb_q <= DJB_SEED;
			fnv_q <= FNV_SEED;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_SLOT_COUNT) begin
					slot_count_q <= cfg_data;
				end else begin
					bucket_count_q <= cfg_data[12:0];
				end
			end
			if (cmd.hash_upd) begin
				djb_q <= (djb_q << 5) + djb_q + {56'd0, key_byte};
				fnv_q <= (fnv_x << 40) + (fnv_x << 8) + (fnv_x << 7) + (fnv_x << 5)
					+ (fnv_x << 4) + (fnv_x << 1) + fnv_x;
			end else if (cmd.hash_seed) begin
				djb_q <= DJB_SEED;
				fnv_q <= FNV_SEED;
			end
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.map_wr && ({20'd0, entry_index} < BDEP)) begin
			bucket_map[BW'(entry_index)] <= multiplier_id;
		end
		if (cmd.map_rd) begin
			map_q <= bucket_map[bucket_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_wr && ({20'd0, entry_index} < MDEP)) begin
			multiplier_table[MW'(entry_index)] <= {alpha, beta};
		end
		if (cmd.mul_rd) begin
			mul_q <= multiplier_table[mid];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.bucket_ld) begin
			bucket_q <= BW'(div_rem);
		end
		if (cmd.mul_lo) begin
			lo_q <= (fnv_q[31:0] * mul_q[63:32]) + {32'd0, mul_q[31:0]};
		end
		if (cmd.mul_hi) begin
			hi_q <= fnv_q[63:32] * mul_q[63:32];
		end
		if (cmd.sum_ld) begin
			sum_q <= djb_q + lo_q + {hi_q[31:0], 32'd0};
		end
		if (cmd.out_ld) begin
			if (cmd.not_init) begin
				slot_q <= '0;
				bucket_out_q <= '0;
				status_q <= STATUS_NOT_INIT;
			end else begin
				slot_q <= div_rem;
				bucket_out_q <= 12'(bucket_q);
				status_q <= STATUS_OK;
			end
		end
	end

	assign st.div_done = div_done;
	assign st.slot_zero = (slot_count_q == 32'd0);
	assign st.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign slot_index = slot_q;
	assign bucket_index = bucket_out_q;
	assign status = status_q;

endmodule

// ===== hdl/phsl_ctrl.sv =====
module phsl_ctrl import phsl_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [1:0]   action,
	input  logic         has_byte,
	input  logic         last_byte,
	input  phsl_status_t st,
	output logic         in_stall,
	output phsl_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_BSTART, S_BDIV, S_MAP, S_MID, S_MLO, S_MHI,
		S_SUM, S_SSTART, S_SDIV, S_OUT
	} state_t;

	state_t state_q;
	logic   not_init_q;
	logic   accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.not_init = not_init_q;
		case (state_q)
			S_IDLE: begin
				cmd.hash_upd = accept && (action == ACT_KEY) && has_byte;
				cmd.map_wr = accept && (action == ACT_WR_MAP);
				cmd.mul_wr = accept && (action == ACT_WR_MUL);
			end
			S_BSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = DIV_SEL_BUCKET;
			end
			S_BDIV: cmd.bucket_ld = st.div_done;
			S_MAP: cmd.map_rd = 1'b1;
			S_MID: cmd.mul_rd = 1'b1;
			S_MLO: cmd.mul_lo = 1'b1;
			S_MHI: cmd.mul_hi = 1'b1;
			S_SUM: cmd.sum_ld = 1'b1;
			S_SSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = DIV_SEL_SLOT;
			end
			S_SDIV: cmd.div_sel = DIV_SEL_SLOT;
			S_OUT: begin
				cmd.div_sel = DIV_SEL_SLOT;
				cmd.out_ld = st.out_free;
				cmd.hash_seed = st.out_free;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			not_init_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && (action == ACT_KEY) && last_byte) begin
						not_init_q <= st.slot_zero;
						state_q <= st.slot_zero ? S_OUT : S_BSTART;
					end
				end
				S_BSTART: state_q <= S_BDIV;
				S_BDIV: if (st.div_done) state_q <= S_MAP;
				S_MAP: state_q <= S_MID;
				S_MID: state_q <= S_MLO;
				S_MLO: state_q <= S_MHI;
				S_MHI: state_q <= S_SUM;
				S_SUM: state_q <= S_SSTART;
				S_SSTART: state_q <= S_SDIV;
				S_SDIV: if (st.div_done) state_q <= S_OUT;
				S_OUT: if (st.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> st.out_free) else $error("result loaded while output busy");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !st.div_done) else $error("divider finished too early");
	a_seed_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |=> (state_q == S_IDLE)) else $error("no return to idle after result");
	a_no_upd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !(cmd.hash_upd || cmd.map_wr || cmd.mul_wr))
		else $error("item taken while busy");
`endif

endmodule

// ===== hdl/perfect_hash_slot_lookup.sv =====
// Perfect hash slot lookup.
// Input channel (in_valid / in_stall): one item per accepted cycle. Action key
// items carry one key byte (has_byte) and mark the key end with last_byte; a
// bare end marker ends an empty key. Table-write items load the bucket map or
// the multiplier table at entry_index and give no result.
// Key bytes and table writes are taken one per cycle while the block is idle.
// After the item that ends a key, in_stall stays high through two passes of the
// shared one-bit-per-cycle divider (bucket and slot reductions), their two
// start states, the two table reads, two 32x32 partial products, the sum and
// the output load. out_valid rises at the edge that drops in_stall.
// With slot_count zero the not-initialized result is loaded right after the
// key end, once the output register is free; in_stall is high only until then.
// Output channel (out_valid / out_stall): one result per key, held in an
// output register until taken. While the receiver stalls a finished result,
// the block waits before returning to idle; a result already in the output
// register does not block new input until the next one is ready.
// Reset clears the hashes to seeds, slot_count to 0, bucket_count to 1. Tables
// are undefined until written. cfg_we writes cfg_data to register cfg_index
// (0 slot_count, 1 bucket_count): user must write only when idle (unchecked).
module perfect_hash_slot_lookup import phsl_pkg::*; #(
	parameter int BUCKET_DEPTH = 4096,
	parameter int MULTIPLIER_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  key_byte,
	input  logic        has_byte,
	input  logic        last_byte,
	input  logic [11:0] entry_index,
	input  logic [7:0]  multiplier_id,
	input  logic [31:0] alpha,
	input  logic [31:0] beta,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] slot_index,
	output logic [11:0] bucket_index,
	output logic        status
);

	phsl_cmd_t    cmd;
	phsl_status_t st;

	phsl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.action    (action),
		.has_byte  (has_byte),
		.last_byte (last_byte),
		.st        (st),
		.in_stall  (in_stall),
		.cmd       (cmd)
	);

	phsl_dp #(
		.BUCKET_DEPTH     (BUCKET_DEPTH),
		.MULTIPLIER_DEPTH (MULTIPLIER_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.key_byte      (key_byte),
		.entry_index   (entry_index),
		.multiplier_id (multiplier_id),
		.alpha         (alpha),
		.beta          (beta),
		.out_stall     (out_stall),
		.cmd           (cmd),
		.st            (st),
		.out_valid     (out_valid),
		.slot_index    (slot_index),
		.bucket_index  (bucket_index),
		.status        (status)
	);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import phsl_pkg::*;

	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
	localparam int MAP_DEPTH = 4096;
	localparam int MUL_DEPTH = 256;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [1:0] act;
		logic [7:0] kb;
		logic has;
		logic last;
		logic [11:0] idx;
		logic [7:0] mid;
		logic [31:0] a;
		logic [31:0] b;
	} lookup_item_t;

	typedef struct packed {
		logic [31:0] slot;
		logic [11:0] bucket;
		logic stat;
	} slot_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] action = '0;
	logic [7:0] key_byte = '0;
	logic has_byte = 1'b0;
	logic last_byte = 1'b0;
	logic [11:0] entry_index = '0;
	logic [7:0] multiplier_id = '0;
	logic [31:0] alpha = '0;
	logic [31:0] beta = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] slot_index;
	logic [11:0] bucket_index;
	logic status;

	perfect_hash_slot_lookup i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .key_byte(key_byte), .has_byte(has_byte),
		.last_byte(last_byte), .entry_index(entry_index),
		.multiplier_id(multiplier_id), .alpha(alpha), .beta(beta),
		.out_valid(out_valid), .out_stall(out_stall),
		.slot_index(slot_index), .bucket_index(bucket_index), .status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the block's state, advanced on every accepted item.
	logic [63:0] djb_hash = DJB_SEED;
	logic [63:0] fnv_hash = FNV_SEED;
	logic [31:0] slot_count_cfg = '0;
	logic [12:0] bucket_count_cfg = 13'd1;
	logic [7:0] bucket_map [MAP_DEPTH];
	logic [63:0] mul_table [MUL_DEPTH];
	bit map_written [MAP_DEPTH];
	// djb2 hash of the key being generated, used to find its bucket ahead of time.
	logic [63:0] gen_djb = DJB_SEED;

	lookup_item_t item_q[$];
	slot_result_t slot_q[$];
	lookup_item_t offer;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_trigger = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int errors = 0;
	int keys_checked = 0;
	int items_taken = 0;
	int cycles = 0;

	function automatic int eff_buckets(logic [12:0] v);
		if (v == 0)
			return 1;
		if (v > MAP_DEPTH)
			return MAP_DEPTH;
		return int'(v);
	endfunction

	function automatic void advance_lookup(lookup_item_t it);
		logic [63:0] bkt;
		logic [63:0] entry;
		logic [63:0] sum;
		slot_result_t r;
		case (it.act)
			ACT_WR_MAP: begin
				if (it.idx < MAP_DEPTH)
					bucket_map[it.idx] = it.mid;
			end
			ACT_WR_MUL: begin
				if (it.idx < MUL_DEPTH)
					mul_table[it.idx] = {it.a, it.b};
			end
			ACT_KEY: begin
				if (it.has) begin
					djb_hash = (djb_hash << 5) + djb_hash + 64'(it.kb);
					fnv_hash = (fnv_hash ^ 64'(it.kb)) * FNV_PRIME;
				end
				if (it.last) begin
					if (slot_count_cfg == 0) begin
						r.slot = '0;
						r.bucket = '0;
						r.stat = STATUS_NOT_INIT;
					end else begin
						bkt = djb_hash % eff_buckets(bucket_count_cfg);
						entry = mul_table[bucket_map[bkt] % MUL_DEPTH];
						sum = djb_hash + fnv_hash * entry[63:32] + entry[31:0];
						r.slot = 32'(sum % slot_count_cfg);
						r.bucket = bkt[11:0];
						r.stat = STATUS_OK;
					end
					slot_q.insert(slot_q.size(), r);
					djb_hash = DJB_SEED;
					fnv_hash = FNV_SEED;
				end
			end
			default: ;
		endcase
	endfunction

	// Driver: a stalled item is held unchanged until it is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				advance_lookup(offer);
				items_taken++;
			end
			if (!(in_valid && in_stall)) begin
				if (item_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					offer = item_q.pop_front();
					in_valid <= 1'b1;
					action <= offer.act;
					key_byte <= offer.kb;
					has_byte <= offer.has;
					last_byte <= offer.last;
					entry_index <= offer.idx;
					multiplier_id <= offer.mid;
					alpha <= offer.a;
					beta <= offer.b;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_trigger != hold_seen) begin
			hold_seen <= hold_trigger;
			hold_left <= 2000;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		slot_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (slot_q.size() == 0) begin
				$display("%0t: result with none expected: slot %0d bucket %0d status %0d",
					$time, slot_index, bucket_index, status);
				errors++;
			end else begin
				want = slot_q.pop_front();
				keys_checked++;
				if (slot_index !== want.slot) begin
					$display("%0t: slot_index expected %0d actual %0d",
						$time, want.slot, slot_index);
					errors++;
				end
				if (bucket_index !== want.bucket) begin
					$display("%0t: bucket_index expected %0d actual %0d",
						$time, want.bucket, bucket_index);
					errors++;
				end
				if (status !== want.stat) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.stat, status);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, slot_q.size());
			$display("perfect_hash_slot_lookup regression: fail");
			$finish;
		end
	end

	// Unused fields carry random values so that every input bit toggles.
	function automatic lookup_item_t noise_item(logic [1:0] act);
		lookup_item_t it;
		it.act = act;
		it.kb = 8'($urandom_range(255));
		it.has = 1'($urandom_range(1));
		it.last = 1'($urandom_range(1));
		it.idx = 12'($urandom_range(4095));
		it.mid = 8'($urandom_range(255));
		it.a = $urandom;
		it.b = $urandom;
		return it;
	endfunction

	task automatic enqueue_item(lookup_item_t it);
		item_q.insert(item_q.size(), it);
	endtask

	task automatic push_map(int idx, logic [7:0] id);
		lookup_item_t it;
		it = noise_item(ACT_WR_MAP);
		it.idx = 12'(idx);
		it.mid = id;
		map_written[idx] = 1'b1;
		enqueue_item(it);
	endtask

	task automatic push_mul(int idx, logic [31:0] a, logic [31:0] b);
		lookup_item_t it;
		it = noise_item(ACT_WR_MUL);
		it.idx = 12'(idx);
		it.a = a;
		it.b = b;
		enqueue_item(it);
	endtask

	// The bucket that the finishing key lands in gets a map entry before its end item.
	task automatic key_end_map();
		logic [63:0] b;
		b = gen_djb % eff_buckets(bucket_count_cfg);
		if (!map_written[b[11:0]])
			push_map(int'(b[11:0]), 8'($urandom_range(255)));
		gen_djb = DJB_SEED;
	endtask

	task automatic push_byte(logic [7:0] kb, logic last);
		lookup_item_t it;
		gen_djb = (gen_djb << 5) + gen_djb + 64'(kb);
		if (last)
			key_end_map();
		it = noise_item(ACT_KEY);
		it.kb = kb;
		it.has = 1'b1;
		it.last = last;
		enqueue_item(it);
	endtask

	task automatic push_marker(logic last);
		lookup_item_t it;
		if (last)
			key_end_map();
		it = noise_item(ACT_KEY);
		it.has = 1'b0;
		it.last = last;
		enqueue_item(it);
	endtask

	// A key may end on its last byte or on a trailing bare end marker.
	task automatic push_key(int len, bit marker_end);
		for (int i = 0; i < len; i++)
			push_byte(8'($urandom_range(255)), (i == len - 1) && !marker_end);
		if (len == 0 || marker_end)
			push_marker(1'b1);
	endtask

	task automatic set_cfg(logic idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_SLOT_COUNT)
			slot_count_cfg = val;
		else
			bucket_count_cfg = val[12:0];
	endtask

	task automatic drain();
		while (item_q.size() != 0 || in_valid || slot_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_items(int n);
		int made;
		int len;
		made = 0;
		while (made < n) begin
			if ($urandom_range(99) < 80) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
				push_key(len, $urandom_range(3) == 0);
				made += len + 1;
			end else begin
				case ($urandom_range(3))
					0: push_map($urandom_range(4095), 8'($urandom_range(255)));
					1: push_mul($urandom_range(1) ? $urandom_range(255) : $urandom_range(4095),
						$urandom, $urandom);
					2: enqueue_item(noise_item(ACT_NONE));
					default: push_marker(1'b0);
				endcase
				made++;
			end
		end
	endtask

	initial begin
		logic [12:0] bc_pick;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset the slot count is zero, so every key reports not initialized.
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);
		push_key(0, 1'b0);
		push_marker(1'b0);
		push_byte(8'h5A, 1'b0);
		push_marker(1'b1);
		enqueue_item(noise_item(ACT_NONE));
		push_key(3, 1'b0);
		drain();

		for (int i = 0; i < MUL_DEPTH; i++) begin
			if (i == 0)
				push_mul(i, 32'h0, 32'h0);
			else if (i == MUL_DEPTH - 1)
				push_mul(i, 32'hFFFFFFFF, 32'hFFFFFFFF);
			else
				push_mul(i, $urandom, $urandom);
		end
		push_mul(4095, $urandom, $urandom);
		push_map(4095, 8'hFF);
		drain();

		// A bucket count of zero behaves as a single bucket.
		set_cfg(CFG_SLOT_COUNT, 32'd1);
		set_cfg(CFG_BUCKET_COUNT, 32'd0);
		push_key(1, 1'b0);
		push_key(0, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b1);
		drain();

		set_cfg(CFG_SLOT_COUNT, 32'hFFFFFFFF);
		set_cfg(CFG_BUCKET_COUNT, 32'd4096);
		push_key(0, 1'b0);
		push_key(5, 1'b1);
		push_byte(8'hFF, 1'b1);
		push_key(40, 1'b0);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 72; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 72; end
				default: begin send_idle_pct = 7; recv_stall_pct = 7; end
			endcase
			case (ph)
				0: bc_pick = 13'd8191;
				1: bc_pick = 13'd1;
				2: bc_pick = 13'd2;
				4: bc_pick = 13'd4096;
				default: bc_pick = 13'($urandom_range(4096, 1));
			endcase
			set_cfg(CFG_BUCKET_COUNT, (ph == 6) ? {19'h7FFFF, bc_pick} : {19'h0, bc_pick});
			if (ph == 3)
				set_cfg(CFG_SLOT_COUNT, 32'd0);
			else if (ph == 5)
				set_cfg(CFG_SLOT_COUNT, $urandom_range(16, 1));
			else
				set_cfg(CFG_SLOT_COUNT, $urandom | 32'd1);
			if (ph == 5)
				hold_trigger <= hold_trigger + 1;
			random_items(180);
			drain();
		end

		$display("Covered %0d accepted items and %0d checked keys over eight random phases,",
			items_taken, keys_checked);
		$display("including reset, extreme and out-of-range register settings and a long stall.");
		if (errors == 0)
			$display("perfect_hash_slot_lookup regression: pass");
		else
			$display("perfect_hash_slot_lookup regression: fail");
		$finish;
	end

endmodule
